// ===== src/pgsh_pkg.sv =====
// Package for the polygon-gated spectrum histogrammer.
// Sizes, request/result types, gate chain types and counter helpers.
// No dependencies.
package pgsh_pkg;

    localparam int BINS_1D      = 4096;
    localparam int SIDE_2D      = 256;
    localparam int MAX_VERTICES = 16;
    localparam int COUNT_WIDTH  = 32;

    localparam int N_1D      = 3;
    localparam int N_2D      = 2;
    localparam int SHIFT_2D  = 4;
    localparam int FRAC_BITS = 4;
    localparam int COORD_W   = 16;
    localparam int OUT_W     = 32;
    localparam int PROD_W    = 2 * (COORD_W + 1);
    localparam int CNT_W     = $clog2(MAX_VERTICES + 1);

    localparam int DEPTH_1D = N_1D * BINS_1D;
    localparam int DEPTH_2D = N_2D * SIDE_2D * SIDE_2D;
    localparam int A1_W     = $clog2(DEPTH_1D);
    localparam int A2_W     = $clog2(DEPTH_2D);
    localparam int CLR_LEN  = (DEPTH_1D > DEPTH_2D) ? DEPTH_1D : DEPTH_2D;
    localparam int CLR_W    = $clog2(CLR_LEN);

    localparam logic [1:0] K_EVENT  = 2'd0;
    localparam logic [1:0] K_VERTEX = 2'd1;
    localparam logic [1:0] K_READ   = 2'd2;
    localparam logic [1:0] K_CLEAR  = 2'd3;

    localparam logic [2:0] SEL_POS   = 3'd0;
    localparam logic [2:0] SEL_ELOSS = 3'd1;
    localparam logic [2:0] SEL_GPOS  = 3'd2;
    localparam logic [2:0] SEL_2D    = 3'd3;
    localparam logic [2:0] SEL_G2D   = 3'd4;

    typedef struct packed {
        logic [1:0]  kind;
        logic [11:0] pos_value;
        logic [11:0] energy_loss_value;
        logic [15:0] vertex_x;
        logic [15:0] vertex_y;
        logic [2:0]  spectrum_select;
        logic [11:0] bin_row;
        logic [7:0]  bin_col;
    } t_req;

    typedef struct packed {
        logic [31:0] bin_count;
        logic        inside_gate;
        logic [31:0] gated_total;
        logic        error;
    } t_res;

    // point travelling down the cell chain
    typedef struct packed {
        logic               valid;
        logic [COORD_W-1:0] px;
        logic [COORD_W-1:0] py;
        logic               parity;
    } t_tok;

    typedef struct packed {
        logic               append;
        logic               test;
        logic [COORD_W-1:0] vx;
        logic [COORD_W-1:0] vy;
        logic [COORD_W-1:0] px;
        logic [COORD_W-1:0] py;
    } t_gate_cmd;

    typedef struct packed {
        logic full;
        logic done;
        logic hit;
    } t_gate_sts;

    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
        if (&v) begin
            return v;
        end
        return v + COUNT_WIDTH'(1);
    endfunction

    function automatic logic [OUT_W-1:0] to_out(input logic [COUNT_WIDTH-1:0] v);
        if ((v >> OUT_W) != '0) begin
            return '1;
        end
        return OUT_W'(v);
    endfunction

endpackage

// ===== src/pgsh_cell.sv =====
// One gate cell: holds a polygon vertex and tests the edge to its predecessor.
// Two register stages: products, then crossing toggle. Uses pgsh_pkg.
module pgsh_cell import pgsh_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_wr,
    input  logic               i_act,
    input  logic [COORD_W-1:0] i_vx,
    input  logic [COORD_W-1:0] i_vy,
    input  logic [COORD_W-1:0] i_prev_x,
    input  logic [COORD_W-1:0] i_prev_y,
    output logic [COORD_W-1:0] o_vx,
    output logic [COORD_W-1:0] o_vy,
    input  t_tok               i_tok,
    output t_tok               o_tok
);

    logic [COORD_W-1:0]       r_vx, r_vy;
    t_tok                     r_s1, r_out, n_out;
    logic                     r_cond, r_dpos, n_cond, n_dpos;
    logic signed [PROD_W-1:0] r_lhs, r_rhs, n_lhs, n_rhs;
    logic signed [COORD_W:0]  dx_p, d, dx_e, dy_p;
    logic                     crossed;

    always_comb begin
        dx_p   = $signed({1'b0, i_tok.px}) - $signed({1'b0, r_vx});
        d      = $signed({1'b0, i_prev_y}) - $signed({1'b0, r_vy});
        dx_e   = $signed({1'b0, i_prev_x}) - $signed({1'b0, r_vx});
        dy_p   = $signed({1'b0, i_tok.py}) - $signed({1'b0, r_vy});
        n_lhs  = dx_p * d;
        n_rhs  = dx_e * dy_p;
        n_cond = i_act && ((r_vy > i_tok.py) != (i_prev_y > i_tok.py));
        n_dpos = i_prev_y > r_vy;
        crossed = r_dpos ? (r_lhs < r_rhs) : (r_lhs > r_rhs);
        n_out        = r_s1;
        n_out.parity = r_s1.parity ^ (r_cond && crossed);
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_vx <= i_vx;
            r_vy <= i_vy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cond <= n_cond;
        r_dpos <= n_dpos;
        r_lhs  <= n_lhs;
        r_rhs  <= n_rhs;
        if (!i_rst_n) begin
            r_s1.valid  <= 1'b0;
            r_out.valid <= 1'b0;
        end else begin
            r_s1  <= i_tok;
            r_out <= n_out;
        end
    end

    assign o_vx  = r_vx;
    assign o_vy  = r_vy;
    assign o_tok = r_out;

endmodule

// ===== src/pgsh_gate_chain.sv =====
// Polygon gate: vertex count, bounding box and the row of vertex cells.
// Uses pgsh_pkg and pgsh_cell.
module pgsh_gate_chain import pgsh_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_gate_cmd i_cmd,
    output t_gate_sts o_sts
);

    logic [CNT_W-1:0]   r_count;
    logic [COORD_W-1:0] r_min_x, r_max_x, r_min_y, r_max_y;
    logic [COORD_W-1:0] r_last_x, r_last_y;
    logic               r_box_ok;
    logic               full, do_append, box_ok;
    logic [COORD_W-1:0] vx_row [MAX_VERTICES];
    logic [COORD_W-1:0] vy_row [MAX_VERTICES];
    t_tok               tok [MAX_VERTICES+1];

    assign full      = r_count >= CNT_W'(MAX_VERTICES);
    assign do_append = i_cmd.append && !full;
    assign box_ok    = (r_count != '0) &&
                       i_cmd.px < r_max_x && i_cmd.px > r_min_x &&
                       i_cmd.py < r_max_y && i_cmd.py > r_min_y;

    always_comb begin
        tok[0].valid  = i_cmd.test;
        tok[0].px     = i_cmd.px;
        tok[0].py     = i_cmd.py;
        tok[0].parity = 1'b0;
    end

    for (genvar i = 0; i < MAX_VERTICES; i++) begin : g_cell
        logic [COORD_W-1:0] prev_x, prev_y;
        if (i == 0) begin : g_first
            assign prev_x = r_last_x;
            assign prev_y = r_last_y;
        end else begin : g_next
            assign prev_x = vx_row[i-1];
            assign prev_y = vy_row[i-1];
        end
        pgsh_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_wr     (do_append && r_count == CNT_W'(i)),
            .i_act    (CNT_W'(i) < r_count),
            .i_vx     (i_cmd.vx),
            .i_vy     (i_cmd.vy),
            .i_prev_x (prev_x),
            .i_prev_y (prev_y),
            .o_vx     (vx_row[i]),
            .o_vy     (vy_row[i]),
            .i_tok    (tok[i]),
            .o_tok    (tok[i+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_min_x  <= '0;
            r_max_x  <= '0;
            r_min_y  <= '0;
            r_max_y  <= '0;
            r_box_ok <= 1'b0;
        end else begin
            if (i_cmd.test) begin
                r_box_ok <= box_ok;
            end
            if (do_append) begin
                r_count <= r_count + CNT_W'(1);
                if (r_count == '0) begin
                    r_min_x <= i_cmd.vx;
                    r_max_x <= i_cmd.vx;
                    r_min_y <= i_cmd.vy;
                    r_max_y <= i_cmd.vy;
                end else begin
                    if (i_cmd.vx > r_max_x) r_max_x <= i_cmd.vx;
                    if (i_cmd.vx < r_min_x) r_min_x <= i_cmd.vx;
                    if (i_cmd.vy > r_max_y) r_max_y <= i_cmd.vy;
                    if (i_cmd.vy < r_min_y) r_min_y <= i_cmd.vy;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_append) begin
            r_last_x <= i_cmd.vx;
            r_last_y <= i_cmd.vy;
        end
    end

    assign o_sts.full = full;
    assign o_sts.done = tok[MAX_VERTICES].valid;
    assign o_sts.hit  = r_box_ok && tok[MAX_VERTICES].parity;

endmodule

// ===== src/polygon_gated_spectrum_histogrammer.sv =====
// Top level of the polygon-gated spectrum histogrammer.
// Uses pgsh_pkg and pgsh_gate_chain; holds both spectrum memories.
//
// One request at a time. An event walks the point down the vertex cell chain
// while the three ungated bins are updated read-modify-write through the
// single-port spectrum memories; inside the gate the two gated bins follow.
// A clear request, and the clearing pass after reset, sweep the memories one
// word a cycle over CLR_LEN addresses (131072); no request is taken during
// the sweep. Bins and the gated counter saturate.
module polygon_gated_spectrum_histogrammer import pgsh_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_req i_in_req,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_res o_out_res
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_RD    = 3'd2;
    localparam logic [2:0] S_WR    = 3'd3;
    localparam logic [2:0] S_WAIT  = 3'd4;
    localparam logic [2:0] S_RDBIN = 3'd5;
    localparam logic [2:0] S_RDOUT = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    localparam logic [2:0] OP_POS   = 3'd0;
    localparam logic [2:0] OP_ELOSS = 3'd1;
    localparam logic [2:0] OP_2D    = 3'd2;
    localparam logic [2:0] OP_G2D   = 3'd3;
    localparam logic [2:0] OP_GPOS  = 3'd4;

    logic [2:0]             r_state, r_op;
    t_req                   r_req;
    logic                   r_err, r_inside, r_clr_result;
    logic [OUT_W-1:0]       r_count;
    logic [COUNT_WIDTH-1:0] r_gated;
    logic [CLR_W-1:0]       r_clr_addr;
    logic                   r_gate_done, r_gate_in;
    logic                   r_out_valid;
    t_res                   r_out;
    logic [COUNT_WIDTH-1:0] r_rd1, r_rd2;
    logic [COUNT_WIDTH-1:0] mem_1d [DEPTH_1D];
    logic [COUNT_WIDTH-1:0] mem_2d [DEPTH_2D];

    logic                   acc;
    t_gate_cmd              gcmd;
    t_gate_sts              gsts;
    logic                   op_is2d, op_ok, rb_1d, rb_2d, rb_ok;
    logic [1:0]             spec1;
    logic                   spec2;
    logic [11:0]            bin1, xb, yb;
    logic [A1_W-1:0]        op_a1, rb_a1, a1;
    logic [A2_W-1:0]        op_a2, rb_a2, a2;
    logic                   w1_en, w2_en;
    logic [COUNT_WIDTH-1:0] w1_data, w2_data;
    logic [2:0]             adv_state, adv_op;

    assign acc        = i_in_valid && r_state == S_IDLE;
    assign o_in_stall = r_state != S_IDLE;

    always_comb begin
        gcmd.append = acc && i_in_req.kind == K_VERTEX;
        gcmd.test   = acc && i_in_req.kind == K_EVENT;
        gcmd.vx     = i_in_req.vertex_x;
        gcmd.vy     = i_in_req.vertex_y;
        gcmd.px     = COORD_W'({i_in_req.pos_value, FRAC_BITS'(0)});
        gcmd.py     = COORD_W'({i_in_req.energy_loss_value, FRAC_BITS'(0)});
    end

    pgsh_gate_chain u_gate (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (gcmd),
        .o_sts   (gsts)
    );

    // bin update addressing
    always_comb begin
        xb      = r_req.pos_value >> SHIFT_2D;
        yb      = r_req.energy_loss_value >> SHIFT_2D;
        op_is2d = 1'b0;
        spec1   = 2'd2;
        spec2   = 1'b0;
        bin1    = r_req.pos_value;
        adv_state = S_DONE;
        adv_op    = r_op;
        case (r_op)
            OP_POS: begin
                spec1     = 2'd0;
                adv_state = S_RD;
                adv_op    = OP_ELOSS;
            end
            OP_ELOSS: begin
                spec1     = 2'd1;
                bin1      = r_req.energy_loss_value;
                adv_state = S_RD;
                adv_op    = OP_2D;
            end
            OP_2D: begin
                op_is2d   = 1'b1;
                adv_state = S_WAIT;
            end
            OP_G2D: begin
                op_is2d   = 1'b1;
                spec2     = 1'b1;
                adv_state = S_RD;
                adv_op    = OP_GPOS;
            end
            default: begin
                spec1 = 2'd2;
            end
        endcase
        op_ok = op_is2d ? (int'(xb) < SIDE_2D && int'(yb) < SIDE_2D)
                        : (int'(bin1) < BINS_1D);
        op_a1 = A1_W'(int'(spec1) * BINS_1D + int'(bin1));
        op_a2 = A2_W'((int'(spec2) * SIDE_2D + int'(xb)) * SIDE_2D + int'(yb));
    end

    // bin read addressing
    always_comb begin
        rb_1d = r_req.spectrum_select == SEL_POS || r_req.spectrum_select == SEL_ELOSS ||
                r_req.spectrum_select == SEL_GPOS;
        rb_2d = r_req.spectrum_select == SEL_2D || r_req.spectrum_select == SEL_G2D;
        rb_ok = rb_1d ? (int'(r_req.bin_row) < BINS_1D)
              : rb_2d ? (int'(r_req.bin_row) < SIDE_2D && int'(r_req.bin_col) < SIDE_2D)
              : 1'b0;
        rb_a1 = A1_W'(int'(r_req.spectrum_select) * BINS_1D + int'(r_req.bin_row));
        rb_a2 = A2_W'(((int'(r_req.spectrum_select) - int'(SEL_2D)) * SIDE_2D
                       + int'(r_req.bin_row)) * SIDE_2D + int'(r_req.bin_col));
    end

    always_comb begin
        a1 = (r_state == S_CLEAR) ? A1_W'(r_clr_addr) : (r_state == S_RDBIN) ? rb_a1 : op_a1;
        a2 = (r_state == S_CLEAR) ? A2_W'(r_clr_addr) : (r_state == S_RDBIN) ? rb_a2 : op_a2;
        w1_en   = (r_state == S_CLEAR && int'(r_clr_addr) < DEPTH_1D) ||
                  (r_state == S_WR && !op_is2d);
        w2_en   = (r_state == S_CLEAR && int'(r_clr_addr) < DEPTH_2D) ||
                  (r_state == S_WR && op_is2d);
        w1_data = (r_state == S_CLEAR) ? '0 : sat_inc(r_rd1);
        w2_data = (r_state == S_CLEAR) ? '0 : sat_inc(r_rd2);
    end

    always_ff @(posedge i_clk) begin
        if (w1_en) begin
            mem_1d[a1] <= w1_data;
        end
        r_rd1 <= mem_1d[a1];
    end

    always_ff @(posedge i_clk) begin
        if (w2_en) begin
            mem_2d[a2] <= w2_data;
        end
        r_rd2 <= mem_2d[a2];
    end

    // gate result may arrive while bin updates are still running
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gate_done <= 1'b0;
            r_gate_in   <= 1'b0;
        end else if (acc) begin
            r_gate_done <= 1'b0;
        end else if (gsts.done) begin
            r_gate_done <= 1'b1;
            r_gate_in   <= gsts.hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr_addr   <= '0;
            r_clr_result <= 1'b0;
            r_gated      <= '0;
            r_op         <= OP_POS;
        end else begin
            case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + CLR_W'(1);
                    if (r_clr_addr == CLR_W'(CLR_LEN - 1)) begin
                        r_state <= r_clr_result ? S_DONE : S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (acc) begin
                        r_req    <= i_in_req;
                        r_err    <= 1'b0;
                        r_inside <= 1'b0;
                        r_count  <= '0;
                        case (i_in_req.kind)
                            K_EVENT: begin
                                r_op    <= OP_POS;
                                r_state <= S_RD;
                            end
                            K_VERTEX: begin
                                r_err   <= gsts.full;
                                r_state <= S_DONE;
                            end
                            K_READ: begin
                                r_state <= S_RDBIN;
                            end
                            default: begin
                                r_gated      <= '0;
                                r_clr_addr   <= '0;
                                r_clr_result <= 1'b1;
                                r_state      <= S_CLEAR;
                            end
                        endcase
                    end
                end
                S_RD: begin
                    if (!op_ok) begin
                        r_err   <= 1'b1;
                        r_op    <= adv_op;
                        r_state <= adv_state;
                    end else begin
                        r_state <= S_WR;
                    end
                end
                S_WR: begin
                    r_op    <= adv_op;
                    r_state <= adv_state;
                end
                S_WAIT: begin
                    if (r_gate_done) begin
                        r_inside <= r_gate_in;
                        if (r_gate_in) begin
                            r_gated <= sat_inc(r_gated);
                            r_op    <= OP_G2D;
                            r_state <= S_RD;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_RDBIN: begin
                    if (!rb_ok) begin
                        r_err   <= 1'b1;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_RDOUT;
                    end
                end
                S_RDOUT: begin
                    r_count <= to_out(rb_1d ? r_rd1 : r_rd2);
                    r_state <= S_DONE;
                end
                default: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_state <= S_IDLE;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && (!r_out_valid || !i_out_stall)) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && (!r_out_valid || !i_out_stall)) begin
            r_out.bin_count   <= r_count;
            r_out.inside_gate <= r_inside;
            r_out.gated_total <= to_out(r_gated);
            r_out.error       <= r_err;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out;

endmodule

// ===== tb/polygon_gated_spectrum_histogrammer_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for polygon_gated_spectrum_histogrammer.
// Directed stimulus table then random requests, checked against a local predictor.
// Depends on pgsh_pkg and the RTL of the block.
module polygon_gated_spectrum_histogrammer_tb;
    import pgsh_pkg::*;

    localparam longint CYCLE_LIMIT = 3000000;
    localparam int     PHASE_ITEMS = 320;

    typedef struct {
        t_req req;
        bit   typed;
        t_res want;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    t_req i_in_req = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    t_res o_out_res;

    polygon_gated_spectrum_histogrammer u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_res   (o_out_res)
    );

    // histogram image and gate held by the predictor
    bit [31:0] hist_1d[int];
    bit [31:0] hist_2d[int];
    bit [15:0] poly_x[MAX_VERTICES];
    bit [15:0] poly_y[MAX_VERTICES];
    int        poly_n;
    bit [15:0] box_min_x, box_max_x, box_min_y, box_max_y;
    bit [31:0] gated_events;

    t_res   expected_results[$];
    t_row   directed_rows[$];
    int     mismatches;
    int     traffic_mode;
    int     hold_seq;
    int     hold_seen = 0;
    int     hold_left = 0;
    longint cycles = 0;
    logic [11:0] last_x, last_y;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("polygon_gated_spectrum_histogrammer: mismatch");
            $finish;
        end
    end

    function automatic bit [31:0] bump(input bit [31:0] v);
        return (&v) ? v : v + 32'd1;
    endfunction

    function automatic bit [31:0] peek(input bit is_2d, input int key);
        if (is_2d) return hist_2d.exists(key) ? hist_2d[key] : 32'd0;
        return hist_1d.exists(key) ? hist_1d[key] : 32'd0;
    endfunction

    function automatic bit point_in_polygon(input longint px, input longint py);
        bit     c;
        int     j;
        longint xi, yi, xj, yj, d, lhs, rhs;
        c = 1'b0;
        if (poly_n == 0) return 1'b0;
        if (!(px < box_max_x && px > box_min_x && py < box_max_y && py > box_min_y))
            return 1'b0;
        for (int i = 0; i < poly_n; i++) begin
            j = (i == 0) ? poly_n - 1 : i - 1;
            xi = poly_x[i]; yi = poly_y[i]; xj = poly_x[j]; yj = poly_y[j];
            if ((yi > py) != (yj > py)) begin
                d = yj - yi;
                lhs = (px - xi) * d;
                rhs = (xj - xi) * (py - yi);
                if ((d > 0) ? (lhs < rhs) : (lhs > rhs)) c = ~c;
            end
        end
        return c;
    endfunction

    function automatic t_res histogram_response(input t_req r);
        t_res o;
        int   k1, k2;
        o = '0;
        k2 = (int'(r.pos_value) >> SHIFT_2D) * SIDE_2D + (int'(r.energy_loss_value) >> SHIFT_2D);
        case (r.kind)
            K_EVENT: begin
                k1 = int'(SEL_POS) * BINS_1D + r.pos_value;
                hist_1d[k1] = bump(peek(0, k1));
                k1 = int'(SEL_ELOSS) * BINS_1D + r.energy_loss_value;
                hist_1d[k1] = bump(peek(0, k1));
                hist_2d[k2] = bump(peek(1, k2));
                o.inside_gate = point_in_polygon(longint'(r.pos_value) * 16,
                                                 longint'(r.energy_loss_value) * 16);
                if (o.inside_gate) begin
                    gated_events = bump(gated_events);
                    k2 += SIDE_2D * SIDE_2D;
                    hist_2d[k2] = bump(peek(1, k2));
                    k1 = int'(SEL_GPOS) * BINS_1D + r.pos_value;
                    hist_1d[k1] = bump(peek(0, k1));
                end
            end
            K_VERTEX: begin
                if (poly_n >= MAX_VERTICES) begin
                    o.error = 1'b1;
                end else begin
                    poly_x[poly_n] = r.vertex_x;
                    poly_y[poly_n] = r.vertex_y;
                    if (poly_n == 0) begin
                        box_min_x = r.vertex_x; box_max_x = r.vertex_x;
                        box_min_y = r.vertex_y; box_max_y = r.vertex_y;
                    end else begin
                        if (r.vertex_x > box_max_x) box_max_x = r.vertex_x;
                        if (r.vertex_x < box_min_x) box_min_x = r.vertex_x;
                        if (r.vertex_y > box_max_y) box_max_y = r.vertex_y;
                        if (r.vertex_y < box_min_y) box_min_y = r.vertex_y;
                    end
                    poly_n++;
                end
            end
            K_READ: begin
                if (r.spectrum_select <= SEL_GPOS) begin
                    if (r.bin_row < BINS_1D)
                        o.bin_count = peek(0, int'(r.spectrum_select) * BINS_1D + r.bin_row);
                    else
                        o.error = 1'b1;
                end else if (r.spectrum_select <= SEL_G2D) begin
                    if (r.bin_row < SIDE_2D && r.bin_col < SIDE_2D)
                        o.bin_count = peek(1, (int'(r.spectrum_select) - int'(SEL_2D))
                                              * SIDE_2D * SIDE_2D
                                              + int'(r.bin_row) * SIDE_2D + r.bin_col);
                    else
                        o.error = 1'b1;
                end else begin
                    o.error = 1'b1;
                end
            end
            default: begin
                hist_1d.delete();
                hist_2d.delete();
                gated_events = '0;
            end
        endcase
        o.gated_total = gated_events;
        return o;
    endfunction

    task automatic report_mismatch(input string field, input longint got, input longint want);
        $display("[%0d] %s: got %0h want %0h", cycles, field, got, want);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result", o_out_res.gated_total, 0);
            end else begin
                want = expected_results.pop_front();
                if (o_out_res.bin_count !== want.bin_count)
                    report_mismatch("bin_count", o_out_res.bin_count, want.bin_count);
                if (o_out_res.inside_gate !== want.inside_gate)
                    report_mismatch("inside_gate", o_out_res.inside_gate, want.inside_gate);
                if (o_out_res.gated_total !== want.gated_total)
                    report_mismatch("gated_total", o_out_res.gated_total, want.gated_total);
                if (o_out_res.error !== want.error)
                    report_mismatch("error", o_out_res.error, want.error);
            end
        end
        if (hold_seen != hold_seq) begin
            hold_seen <= hold_seq;
            hold_left <= 400;
            i_out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (traffic_mode == 2) begin
            i_out_stall <= ($urandom_range(99) < 45);
        end else if (traffic_mode == 3) begin
            i_out_stall <= ($urandom_range(99) < 10);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    task automatic send_request(input t_req r, input bit typed, input t_res want);
        t_res p;
        if ((traffic_mode == 1 && $urandom_range(99) < 45) ||
            (traffic_mode == 3 && $urandom_range(99) < 10)) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_in_req <= r;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        p = histogram_response(r);
        expected_results.insert(expected_results.size(), typed ? want : p);
    endtask

    function automatic t_req make_req(input logic [1:0] kind, input int x, input int y,
                                      input int vx, input int vy, input int sel,
                                      input int row, input int col);
        t_req r;
        r.kind = kind;
        r.pos_value = 12'(x);
        r.energy_loss_value = 12'(y);
        r.vertex_x = 16'(vx);
        r.vertex_y = 16'(vy);
        r.spectrum_select = 3'(sel);
        r.bin_row = 12'(row);
        r.bin_col = 8'(col);
        return r;
    endfunction

    function automatic void add_row(input t_req r, input bit typed, input t_res want);
        t_row w;
        w.req = r;
        w.typed = typed;
        w.want = want;
        directed_rows.insert(directed_rows.size(), w);
    endfunction

    function automatic t_req random_req(input bit near_gate);
        t_req r;
        int   pick;
        r = make_req(K_EVENT, $urandom_range(4095), $urandom_range(4095), $urandom_range(65535),
                     $urandom_range(65535), $urandom_range(7), $urandom_range(4095),
                     $urandom_range(255));
        pick = $urandom_range(99);
        if (pick < 68) begin
            if (near_gate && $urandom_range(3) != 0) begin
                r.pos_value = 12'($urandom_range(64, 2200));
                r.energy_loss_value = 12'($urandom_range(64, 2200));
            end
            last_x = r.pos_value;
            last_y = r.energy_loss_value;
        end else if (pick < 98) begin
            r.kind = K_READ;
            if ($urandom_range(9) < 7) begin
                r.spectrum_select = 3'($urandom_range(SEL_G2D));
                if (r.spectrum_select >= SEL_2D) begin
                    r.bin_row = last_x >> SHIFT_2D;
                    r.bin_col = 8'(last_y >> SHIFT_2D);
                end else begin
                    r.bin_row = (r.spectrum_select == SEL_ELOSS) ? last_y : last_x;
                end
            end
        end else begin
            r.kind = K_VERTEX;
        end
        return r;
    endfunction

    initial begin
        t_res z;
        t_res e;
        t_req r;
        z = '0;
        e = '0;
        e.error = 1'b1;
        mismatches = 0;
        traffic_mode = 0;
        hold_seq = 0;
        last_x = '0;
        last_y = '0;
        poly_n = 0;
        gated_events = '0;
        {box_min_x, box_max_x, box_min_y, box_max_y} = '0;

        add_row(make_req(K_READ, 0, 0, 0, 0, SEL_POS, 0, 0), 1, z);
        add_row(make_req(K_EVENT, 0, 0, 0, 0, 0, 0, 0), 1, z);
        add_row(make_req(K_EVENT, 4095, 4095, 65535, 65535, 7, 4095, 255), 1, z);
        add_row(make_req(K_READ, 0, 0, 0, 0, SEL_POS, 4095, 0), 0, z);
        add_row(make_req(K_READ, 0, 0, 0, 0, SEL_ELOSS, 0, 0), 0, z);
        add_row(make_req(K_READ, 0, 0, 0, 0, SEL_2D, 255, 255), 0, z);
        add_row(make_req(K_READ, 0, 0, 0, 0, SEL_2D, 256, 0), 1, e);
        add_row(make_req(K_READ, 0, 0, 0, 0, 5, 0, 0), 1, e);
        add_row(make_req(K_READ, 0, 0, 0, 0, 7, 0, 0), 1, e);
        // concave pentagon with a notch from the top
        add_row(make_req(K_VERTEX, 0, 0, 16'h1000, 16'h1000, 0, 0, 0), 1, z);
        add_row(make_req(K_VERTEX, 0, 0, 16'h8000, 16'h1000, 0, 0, 0), 1, z);
        add_row(make_req(K_VERTEX, 0, 0, 16'h8000, 16'h8000, 0, 0, 0), 1, z);
        add_row(make_req(K_VERTEX, 0, 0, 16'h4800, 16'h4000, 0, 0, 0), 1, z);
        add_row(make_req(K_VERTEX, 0, 0, 16'h1000, 16'h8000, 0, 0, 0), 1, z);
        add_row(make_req(K_EVENT, 12'h300, 12'h200, 0, 0, 0, 0, 0), 0, z);
        add_row(make_req(K_EVENT, 12'h480, 12'h700, 0, 0, 0, 0, 0), 0, z);
        add_row(make_req(K_EVENT, 12'h100, 12'h300, 0, 0, 0, 0, 0), 0, z);
        add_row(make_req(K_EVENT, 12'h7FF, 12'h7FF, 0, 0, 0, 0, 0), 0, z);
        add_row(make_req(K_READ, 0, 0, 0, 0, SEL_GPOS, 12'h300, 0), 0, z);
        add_row(make_req(K_READ, 0, 0, 0, 0, SEL_G2D, 12'h30, 8'h20), 0, z);
        add_row(make_req(K_CLEAR, 0, 0, 0, 0, 0, 0, 0), 1, z);
        add_row(make_req(K_READ, 0, 0, 0, 0, SEL_POS, 12'h300, 0), 1, z);
        add_row(make_req(K_EVENT, 12'h300, 12'h200, 0, 0, 0, 0, 0), 0, z);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);

        for (int m = 0; m < 4; m++) begin
            traffic_mode = m;
            if (m == 0) hold_seq++;
            if (m == 2) begin
                // fill the vertex table, then overflow it
                for (int v = 0; v < MAX_VERTICES - 5 + 3; v++) begin
                    r = make_req(K_VERTEX, 0, 0, $urandom_range(16'h0800, 16'h9000),
                                 $urandom_range(16'h0800, 16'h9000), 0, 0, 0);
                    if (v == 0) r.vertex_x = 16'hFFFF;
                    if (v == 1) r.vertex_y = 16'hFFFF;
                    if (v == MAX_VERTICES - 5) r.vertex_x = 16'h0000;
                    send_request(r, 0, z);
                end
            end
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_request(random_req(1'b1), 0, z);
            if (m == 1 || m == 3)
                send_request(make_req(K_CLEAR, 0, 0, 0, 0, 0, 0, 0), 0, z);
        end
        i_in_valid <= 1'b0;

        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("polygon_gated_spectrum_histogrammer: match");
        end else begin
            $display("polygon_gated_spectrum_histogrammer: mismatch");
        end
        $finish;
    end

endmodule

// ===== polygon_gated_spectrum_histogrammer.f =====
src/pgsh_pkg.sv
src/pgsh_cell.sv
src/pgsh_gate_chain.sv
src/polygon_gated_spectrum_histogrammer.sv
tb/polygon_gated_spectrum_histogrammer_tb.sv
